// ----- rtl/core/tvs_pkg.sv -----
// tvs_pkg: shared types and constants for the turtle vector step engine.
// Word structs, command codes, the CORDIC arctangent table and the gain helper.
// No dependencies.
package tvs_pkg;

  localparam int XW        = 52;
  localparam int GUARD     = 16;
  localparam int DW        = XW - GUARD;
  localparam int ZW        = 34;
  localparam int STEP_W    = 5;
  localparam int ATAN_N    = 30;
  localparam int GAIN_FRAC = 30;
  localparam int REM_W     = 9;
  localparam int DEG_HALF  = 180;
  localparam int DEG_FULL  = 360;

  localparam logic [2:0] CMD_RESET    = 3'd0;
  localparam logic [2:0] CMD_PEN_DOWN = 3'd1;
  localparam logic [2:0] CMD_PEN_UP   = 3'd2;
  localparam logic [2:0] CMD_TURN     = 3'd3;
  localparam logic [2:0] CMD_MOVE     = 3'd4;

  localparam logic RES_CLEAR = 1'b0;
  localparam logic RES_LINE  = 1'b1;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] amount;
  } tvs_in_t;

  typedef struct packed {
    logic               kind_res;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } tvs_out_t;

  // arctan(2^-i) in binary angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // floor(sqrt(P * 2^30)) where P is the CORDIC gain squared in Q30
  function automatic logic [63:0] tvs_gain_root(input int steps);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bit_v;
    p = 64'd1 << 30;
    for (int i = 0; i < ATAN_N; i++) begin
      if (i < steps) begin
        p = p + (p >> (2 * i));
      end
    end
    n     = p << 30;
    root  = 64'd0;
    bit_v = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_v > n) begin
        bit_v = bit_v >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_v != 64'd0) begin
        if (n >= root + bit_v) begin
          n    = n - (root + bit_v);
          root = (root >> 1) + bit_v;
        end else begin
          root = root >> 1;
        end
        bit_v = bit_v >> 2;
      end
    end
    return root;
  endfunction

endpackage

// ----- rtl/core/tvs_divider.sv -----
// tvs_divider: degrees to binary angle, floor((amount * 2^(32-F) + 180) / 360).
// Long division by 360 in 16-bit digits, one reciprocal multiply per digit. Depends on tvs_pkg.
module tvs_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] amount,
  output logic               done,
  output logic [31:0]        quot
);
  import tvs_pkg::*;

  localparam int SHIFT   = 32 - FRAC_BITS;
  // offset of 360 * 2^OFF_EXP keeps the dividend positive; only the quotient
  // bits above 31 move, which the heading wrap drops
  localparam int OFF_EXP = 31 + SHIFT;
  localparam int DIV_W   = OFF_EXP + REM_W;
  localparam int DIG_W   = 16;
  localparam int DIGITS  = 4;
  localparam int NUM_W   = DIG_W * DIGITS;
  localparam int T_W     = REM_W + DIG_W;
  localparam int RCP_SH  = 34;
  localparam int PROD_W  = RCP_SH + DIG_W;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIGITS - 1);
  // ceil(2^RCP_SH / 360), exact for any partial dividend below 360 * 2^DIG_W
  localparam logic [63:0] RCP = ((64'd1 << RCP_SH) + 64'(DEG_FULL - 1)) / 64'(DEG_FULL);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t            state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               done_r, done_nxt;

  logic signed [DIV_W-1:0] amt_ext;
  logic [DIV_W-1:0]        num;
  logic [T_W-1:0]          trial;
  logic [PROD_W-1:0]       prod;
  logic [DIG_W-1:0]        qdig;
  logic [T_W-1:0]          back;

  assign amt_ext = DIV_W'(amount);
  assign num     = DIV_W'(amt_ext <<< SHIFT) + DIV_W'(DEG_HALF)
                 + (DIV_W'(DEG_FULL) << OFF_EXP);
  assign trial   = {rem_r, dvd_r[NUM_W-1 -: DIG_W]};
  assign prod    = PROD_W'(trial) * PROD_W'(RCP);
  assign qdig    = prod[PROD_W-1 -: DIG_W];
  assign back    = T_W'(qdig) * T_W'(DEG_FULL);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          dvd_nxt   = NUM_W'(num);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = REM_W'(trial - back);
        dvd_nxt = {dvd_r[NUM_W-DIG_W-1:0], qdig};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r[31:0];

endmodule

// ----- rtl/core/tvs_rotator.sv -----
// tvs_rotator: length times (cos, sin) of a binary-angle heading.
// Gain multiply, half-turn fold, one shared CORDIC stage, rounding. Uses tvs_pkg.
module tvs_rotator #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [31:0]           len,
  input  logic [31:0]                  heading,
  output logic                         done,
  output logic signed [tvs_pkg::DW-1:0] dx,
  output logic signed [tvs_pkg::DW-1:0] dy
);
  import tvs_pkg::*;

  localparam logic [63:0] GAIN_ROOT = tvs_gain_root(CORDIC_STEPS);
  localparam logic [63:0] GAIN_Q30  = ((64'd1 << 60) + GAIN_ROOT / 2) / GAIN_ROOT;
  localparam logic signed [31:0] GAIN_K = {1'b0, GAIN_Q30[30:0]};
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic signed [XW-1:0] RND_HALF = XW'(1) << (GUARD - 1);

  typedef enum logic [1:0] {R_IDLE, R_LOAD, R_ROT, R_RND} rstate_t;

  rstate_t                 state_r, state_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                    fold_r, fold_nxt;
  logic signed [63:0]      prod_r, prod_nxt;
  logic signed [XW-1:0]    x_r, x_nxt;
  logic signed [XW-1:0]    y_r, y_nxt;
  logic signed [ZW-1:0]    z_r, z_nxt;
  logic signed [DW-1:0]    dx_r, dx_nxt;
  logic signed [DW-1:0]    dy_r, dy_nxt;
  logic                    done_r, done_nxt;

  logic                    fold;
  logic signed [31:0]      h_fold;
  logic signed [63:0]      prod_sh;
  logic signed [XW-1:0]    x_load;
  logic signed [XW-1:0]    sx;
  logic signed [XW-1:0]    sy;
  logic signed [ZW-1:0]    at_ext;
  logic signed [XW-1:0]    rx;
  logic signed [XW-1:0]    ry;

  assign fold    = heading[31] ^ heading[30];
  assign h_fold  = {heading[31] ^ fold, heading[30:0]};
  assign prod_sh = prod_r >>> (GAIN_FRAC - GUARD);
  assign x_load  = prod_sh[XW-1:0];
  assign sx      = x_r >>> cnt_r;
  assign sy      = y_r >>> cnt_r;
  assign at_ext  = ZW'(ATAN_TAB[cnt_r]);
  assign rx      = x_r + RND_HALF;
  assign ry      = y_r + RND_HALF;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fold_nxt  = fold_r;
    prod_nxt  = prod_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    done_nxt  = 1'b0;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          prod_nxt  = len * GAIN_K;
          fold_nxt  = fold;
          z_nxt     = ZW'(h_fold);
          state_nxt = R_LOAD;
        end
      end
      R_LOAD: begin
        x_nxt     = fold_r ? -x_load : x_load;
        y_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = R_ROT;
      end
      R_ROT: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - at_ext;
        end else begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + at_ext;
        end
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = R_RND;
        end
      end
      R_RND: begin
        dx_nxt    = rx[XW-1:GUARD];
        dy_nxt    = ry[XW-1:GUARD];
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    fold_r <= fold_nxt;
    prod_r <= prod_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

  assign done = done_r;
  assign dx   = dx_r;
  assign dy   = dy_r;

endmodule

// ----- rtl/core/turtle_vector_step.sv -----
// turtle_vector_step: top level of the turtle-graphics engine.
// Instantiates tvs_rotator and tvs_divider; uses tvs_pkg.
//
// Takes one command word at a time and holds in_stall high while it works.
// Pen commands never raise in_stall. A reset command passes through S_CLR and
// waits there while the output register still holds a stalled word. A turn runs
// four 16-bit digit steps of the divide by 360, each one reciprocal multiply. A
// move's time is set by the single CORDIC stage reused once per iteration, plus
// any wait for the output register when a segment is drawn. A result word waiting
// in the output register does not hold up the next command unless that command
// also produces a word.
module turtle_vector_step #(
  parameter int CORDIC_STEPS = 20,
  parameter int FRAC_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tvs_pkg::tvs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tvs_pkg::tvs_out_t out_data
);
  import tvs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TURN, S_MOVE, S_UPD, S_CLR} state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [31:0]        heading_r, heading_nxt;
  logic               pen_r, pen_nxt;
  logic               out_valid_r, out_valid_nxt;
  tvs_out_t           out_data_r, out_data_nxt;

  logic               accept;
  logic               slot_free;
  logic               rot_start;
  logic               rot_done;
  logic signed [DW-1:0] rot_dx;
  logic signed [DW-1:0] rot_dy;
  logic               div_start;
  logic               div_done;
  logic [31:0]        div_quot;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                 input logic signed [DW-1:0] d);
    logic signed [DW:0] s;
    s = (DW+1)'(p) + (DW+1)'(d);
    if ((&s[DW:31]) || !(|s[DW:31])) begin
      return s[31:0];
    end
    return s[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign rot_start = accept && (in_data.kind == CMD_MOVE);
  assign div_start = accept && (in_data.kind == CMD_TURN);
  assign new_x     = sat_add(pos_x_r, rot_dx);
  assign new_y     = sat_add(pos_y_r, rot_dy);

  tvs_rotator #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_rotator (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rot_start),
    .len     (in_data.amount),
    .heading (heading_r),
    .done    (rot_done),
    .dx      (rot_dx),
    .dy      (rot_dy)
  );

  tvs_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .amount (in_data.amount),
    .done   (div_done),
    .quot   (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    pen_nxt       = pen_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            CMD_RESET: begin
              pos_x_nxt   = '0;
              pos_y_nxt   = '0;
              heading_nxt = '0;
              pen_nxt     = 1'b1;
              state_nxt   = S_CLR;
            end
            CMD_PEN_DOWN: pen_nxt   = 1'b1;
            CMD_PEN_UP:   pen_nxt   = 1'b0;
            CMD_TURN:     state_nxt = S_TURN;
            CMD_MOVE:     state_nxt = S_MOVE;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_TURN: begin
        if (div_done) begin
          heading_nxt = heading_r + div_quot;
          state_nxt   = S_IDLE;
        end
      end
      S_MOVE: begin
        if (rot_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (!pen_r || slot_free) begin
          pos_x_nxt = new_x;
          pos_y_nxt = new_y;
          state_nxt = S_IDLE;
          if (pen_r) begin
            out_valid_nxt         = 1'b1;
            out_data_nxt.kind_res = RES_LINE;
            out_data_nxt.start_x  = pos_x_r;
            out_data_nxt.start_y  = pos_y_r;
            out_data_nxt.end_x    = new_x;
            out_data_nxt.end_y    = new_y;
          end
        end
      end
      S_CLR: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.kind_res = RES_CLEAR;
          out_data_nxt.start_x  = '0;
          out_data_nxt.start_y  = '0;
          out_data_nxt.end_x    = '0;
          out_data_nxt.end_y    = '0;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      heading_r   <= '0;
      pen_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/tvs_checker.sv -----
// tvs_port_checks: port-level checks for turtle_vector_step, bound to the top level.
// Depends on tvs_pkg and turtle_vector_step.
module tvs_port_checks (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input tvs_pkg::tvs_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input tvs_pkg::tvs_out_t out_data
);
  import tvs_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // pen commands finish in the cycle they are taken
  a_pen_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.kind == CMD_PEN_DOWN || in_data.kind == CMD_PEN_UP)
    |=> !in_stall)
    else $error("pen command kept the block busy");

  // a move occupies the engine
  a_move_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == CMD_MOVE |=> in_stall)
    else $error("move command did not hold the input stalled");

  // a clear word always points at the origin
  a_clear_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind_res == RES_CLEAR |->
    out_data.start_x == 32'sd0 && out_data.start_y == 32'sd0 &&
    out_data.end_x == 32'sd0 && out_data.end_y == 32'sd0)
    else $error("clear word with non-zero coordinates");

endmodule

bind turtle_vector_step tvs_port_checks u_tvs_checker (.*);

// ----- tb/tvs_checker.sv -----
// tvs_checker: watches both channels of turtle_vector_step, predicts each result word
// from the accepted commands and compares. Uses tvs_pkg for the word types and codes.
`timescale 1ns / 100ps

module tvs_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  tvs_pkg::tvs_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  tvs_pkg::tvs_out_t out_data,
  output int                fail_count,
  output int                pending,
  output int                lines_seen,
  output int                clears_seen
);
  import tvs_pkg::*;

  localparam int     ROT_STEPS = 20;
  localparam int     FRAC      = 16;
  localparam int     GUARD_W   = 16;
  localparam longint HALF_DEG  = 180;
  localparam longint FULL_DEG  = 360;
  localparam longint POS_MAX   = 64'sh7FFF_FFFF;
  localparam longint POS_MIN   = -64'sh8000_0000;

  // arctan(2^-i), 2^32 to the full turn
  localparam longint ARC_TAB [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304
  };

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        heading;
  logic               pen_down;
  longint             gain_k;
  tvs_out_t           expected_words [$];

  // gain correction in Q30 for ROT_STEPS iterations
  initial begin : gain_calc
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bitv;
    p = 64'd1 << 30;
    for (int i = 0; i < ROT_STEPS; i++) p = p + (p >> (2 * i));
    n    = p << 30;
    root = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    gain_k = longint'(((64'd1 << 60) + root / 2) / root);
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > POS_MAX) return 32'sh7FFF_FFFF;
    if (v < POS_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void cordic_rotate(input logic signed [31:0] len, input logic [31:0] hdg,
                                        output longint dx, output longint dy);
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    logic [31:0] h;
    h = hdg;
    x = (longint'(len) * gain_k) >>> (30 - GUARD_W);
    y = 0;
    // fold the left half-plane onto the right by a half turn
    if (h[31:30] == 2'b01 || h[31:30] == 2'b10) begin
      h = h - 32'h8000_0000;
      x = -x;
    end
    z = longint'($signed(h));
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARC_TAB[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARC_TAB[i];
      end
      x = nx;
    end
    dx = (x + (longint'(1) << (GUARD_W - 1))) >>> GUARD_W;
    dy = (y + (longint'(1) << (GUARD_W - 1))) >>> GUARD_W;
  endfunction

  task automatic report_fault(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    tvs_out_t           want;
    tvs_out_t           got;
    longint             dx;
    longint             dy;
    longint             num;
    longint             q;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    if (!rst_n) begin
      pos_x       = '0;
      pos_y       = '0;
      heading     = '0;
      pen_down    = 1'b1;
      fail_count  = 0;
      pending     = 0;
      lines_seen  = 0;
      clears_seen = 0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_words.size() == 0) begin
          report_fault($sformatf("unexpected word kind_res %0d end (%0d, %0d)",
                                 got.kind_res, got.end_x, got.end_y));
        end else begin
          want = expected_words.pop_front();
          if (got.kind_res !== want.kind_res)
            report_fault($sformatf("kind_res got %0d, expected %0d",
                                   got.kind_res, want.kind_res));
          if (got.start_x !== want.start_x)
            report_fault($sformatf("start_x got %0d, expected %0d", got.start_x, want.start_x));
          if (got.start_y !== want.start_y)
            report_fault($sformatf("start_y got %0d, expected %0d", got.start_y, want.start_y));
          if (got.end_x !== want.end_x)
            report_fault($sformatf("end_x got %0d, expected %0d", got.end_x, want.end_x));
          if (got.end_y !== want.end_y)
            report_fault($sformatf("end_y got %0d, expected %0d", got.end_y, want.end_y));
          if (want.kind_res == RES_LINE) lines_seen++;
          else clears_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        want = '0;
        case (in_data.kind)
          CMD_RESET: begin
            pos_x    = '0;
            pos_y    = '0;
            heading  = '0;
            pen_down = 1'b1;
            want.kind_res = RES_CLEAR;
            expected_words.push_back(want);
          end
          CMD_PEN_DOWN: pen_down = 1'b1;
          CMD_PEN_UP:   pen_down = 1'b0;
          CMD_TURN: begin
            // degrees to binary angle, nearest with ties upward
            num = longint'(in_data.amount) * (longint'(1) << (32 - FRAC)) + HALF_DEG;
            q   = num / FULL_DEG;
            if (num % FULL_DEG < 0) q = q - 1;
            heading = heading + q[31:0];
          end
          CMD_MOVE: begin
            cordic_rotate(in_data.amount, heading, dx, dy);
            nx = clamp32(longint'(pos_x) + dx);
            ny = clamp32(longint'(pos_y) + dy);
            if (pen_down) begin
              want.kind_res = RES_LINE;
              want.start_x  = pos_x;
              want.start_y  = pos_y;
              want.end_x    = nx;
              want.end_y    = ny;
              expected_words.push_back(want);
            end
            pos_x = nx;
            pos_y = ny;
          end
          default: ;
        endcase
      end
      pending = expected_words.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: top of the turtle_vector_step test. Drives directed then random commands
// with random gaps and output stalls; tvs_checker does the prediction. Uses tvs_pkg.
`timescale 1ns / 100ps

module testbench;
  import tvs_pkg::*;

  localparam int         RAND_ITEMS    = 700;
  localparam logic [2:0] CMD_LAST_CODE = 3'd7;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  tvs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tvs_out_t out_data;

  logic calm = 1'b0;
  int   items_sent = 0;
  int   fail_count;
  int   pending;
  int   lines_seen;
  int   clears_seen;
  int   hold_left = 0;

  always #10 clk = ~clk;

  turtle_vector_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  tvs_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .lines_seen  (lines_seen),
    .clears_seen (clears_seen)
  );

  // receiver: draws a random stall after each word it takes
  always @(posedge clk) begin : rx_side
    int k;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      k = calm ? 0 : $urandom_range(0, 6);
      out_stall <= (k > 0);
      hold_left <= k;
    end else if (out_stall) begin
      if (hold_left <= 1) out_stall <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  function automatic logic [31:0] q16(input int v);
    return v * 65536;
  endfunction

  task automatic send_cmd(input logic [2:0] k, input logic [31:0] a);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tvs_in_t'({k, a});
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          r;
    int          sel;
    logic [2:0]  k;
    logic [31:0] a;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: quadrants, zero and unit lengths, pen up, saturation, wide angles
    send_cmd(CMD_RESET, $urandom);
    send_cmd(CMD_MOVE, q16(10));
    send_cmd(CMD_MOVE, 32'h0);
    send_cmd(CMD_TURN, q16(90));
    send_cmd(CMD_MOVE, q16(5));
    send_cmd(CMD_TURN, q16(90));
    send_cmd(CMD_MOVE, q16(7));
    send_cmd(CMD_TURN, q16(90));
    send_cmd(CMD_MOVE, -q16(3));
    send_cmd(CMD_TURN, -q16(45));
    send_cmd(CMD_MOVE, 32'h1);
    send_cmd(CMD_PEN_UP, $urandom);
    send_cmd(CMD_MOVE, q16(20));
    send_cmd(CMD_PEN_DOWN, $urandom);
    send_cmd(CMD_MOVE, 32'h7FFF_FFFF);
    send_cmd(CMD_MOVE, 32'h8000_0000);
    send_cmd(CMD_TURN, 32'h7FFF_FFFF);
    send_cmd(CMD_MOVE, 32'h8000_0000);
    send_cmd(CMD_TURN, 32'h8000_0000);
    send_cmd(CMD_MOVE, 32'h7FFF_FFFF);
    for (int c = CMD_MOVE + 1; c <= CMD_LAST_CODE; c++) send_cmd(3'(c), $urandom);
    send_cmd(CMD_MOVE, q16(1));
    send_cmd(CMD_RESET, 32'hFFFF_FFFF);
    send_cmd(CMD_MOVE, q16(2));
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 250) calm <= 1'b1;
      if (n == 350) calm <= 1'b0;
      if (n == 150 || n == 500) drain_results();
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      a = $urandom;
      if (r < 3) begin
        k = CMD_RESET;
      end else if (r < 13) begin
        k = CMD_PEN_DOWN;
      end else if (r < 23) begin
        k = CMD_PEN_UP;
      end else if (r < 50) begin
        k = CMD_TURN;
        if (sel < 2) a = q16((int'($urandom_range(0, 16)) - 8) * 45);
        else if (sel < 9) a = int'($urandom_range(0, 47185920)) - 23592960;
      end else if (r < 97) begin
        k = CMD_MOVE;
        if (sel < 5) a = int'($urandom_range(0, 4194304)) - 2097152;
        else if (sel < 8) a = int'($urandom_range(0, 67108864)) - 33554432;
        else if (sel == 9) begin
          case ($urandom_range(0, 2))
            0: a = 32'h7FFF_FFFF;
            1: a = 32'h8000_0000;
            default: a = 32'h0;
          endcase
        end
      end else begin
        k = 3'(CMD_MOVE + $urandom_range(1, 3));
      end
      send_cmd(k, a);
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("Sent %0d commands; checked %0d segments and %0d clears,", items_sent,
             lines_seen, clears_seen);
    $display("across all headings, pen states, saturation and spare codes.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
